// ===== design/assert_macros.svh =====
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== design/bsc_pkg.sv =====
// types and constants of the barometric sensor compensation block
package bsc_pkg;

    localparam int RAW_W  = 20;
    localparam int CAL_W  = 16;
    localparam int WORD_W = 64;
    localparam int T_W    = 32;
    localparam int DIV_W  = 64;
    localparam int IDX_W  = 3;

    localparam logic signed [33:0] T_OFFSET   = 34'sd128000;
    localparam logic [20:0]        FULL_SCALE = 21'd1048576;
    localparam logic [11:0]        P_SCALE    = 12'd3125;
    localparam logic [63:0]        P_BIAS     = 64'h0000_8000_0000_0000;

    typedef enum logic [IDX_W-1:0] {
        CFG_T1    = 3'd0,
        CFG_T2    = 3'd1,
        CFG_T3    = 3'd2,
        CFG_P1    = 3'd3,
        CFG_P2_P5 = 3'd4,
        CFG_P6_P9 = 3'd5
    } cfg_idx_t;

    // side information traveling with an item through the divider
    typedef struct packed {
        logic [T_W-1:0] tf;
        logic [T_W-1:0] tc;
        logic           inv;
        logic           neg;
    } side_t;

    typedef struct packed {
        logic           inv;
        logic [T_W-1:0] press;
        logic [T_W-1:0] tc;
        logic [T_W-1:0] tf;
    } res_t;

endpackage

// ===== design/bsc_div.sv =====
// pipelined signed 64-bit divider, one quotient bit per stage
module bsc_div
    import bsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [DIV_W-1:0]  num,
    input  logic [DIV_W-1:0]  den,
    input  side_t             side_in,
    output logic              out_vld,
    output logic [DIV_W-1:0]  quo,
    output side_t             side_out
);

    logic [DIV_W-1:0] rem_reg [0:DIV_W];
    logic [DIV_W-1:0] nq_reg  [0:DIV_W];
    logic [DIV_W-1:0] ad_reg  [0:DIV_W];
    side_t            sd_reg  [0:DIV_W];
    logic [DIV_W:0]   v_reg;

    // magnitude and sign setup
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]     <= '0;
            nq_reg[0]      <= num[DIV_W-1] ? (~num + 1'b1) : num;
            ad_reg[0]      <= den[DIV_W-1] ? (~den + 1'b1) : den;
            sd_reg[0].tf   <= side_in.tf;
            sd_reg[0].tc   <= side_in.tc;
            sd_reg[0].inv  <= (den == '0);
            sd_reg[0].neg  <= num[DIV_W-1] ^ den[DIV_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[DIV_W-1:0], in_vld};
        end
    end

    genvar k;
    generate
        for (k = 1; k <= DIV_W; k++)
        begin : g_step
            logic [DIV_W-1:0] sh;
            logic             ge;
            // for a nonzero divisor the remainder stays below it, so its top bit is always clear
            assign sh = {rem_reg[k-1][DIV_W-2:0], nq_reg[k-1][DIV_W-1]};
            assign ge = (sh >= ad_reg[k-1]);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? (sh - ad_reg[k-1]) : sh;
                    nq_reg[k]  <= {nq_reg[k-1][DIV_W-2:0], ge};
                    ad_reg[k]  <= ad_reg[k-1];
                    sd_reg[k]  <= sd_reg[k-1];
                end
            end
        end
    endgenerate

    assign out_vld  = v_reg[DIV_W];
    assign quo      = nq_reg[DIV_W];
    assign side_out = sd_reg[DIV_W];

endmodule

// ===== design/baro_sensor_compensation.sv =====
// top level: barometric sensor compensation pipeline
//
// channel    dir  transfer holds
// s_axis     in   tdata: raw_temp, raw_press
// m_axis     out  tdata: fine_temp, temp_centi, press_q24_8; tuser: press_invalid
// cfg        in   one calibration register write per cycle with cfg_we high
//
// one transfer accepted per cycle while s_axis_tready is high, one result per transfer, in order
// the pipeline has 10 temperature/pressure stages, 65 divider stages
// (setup plus one quotient bit each), 5 post stages and the output register
// the divider sets the depth; every multiplier is at most 34x34 or 64x16
// reset clears valid bits, skid state and calibration registers
// a stalled output fills the skid register, then s_axis_tready drops
`include "assert_macros.svh"
module baro_sensor_compensation
    import bsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [2*RAW_W-1:0]    s_axis_tdata,   // raw_temp, raw_press
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [3*T_W-1:0]      m_axis_tdata,   // fine_temp, temp_centi, press_q24_8
    output logic                  m_axis_tuser,   // press_invalid
    input  logic                  cfg_we,
    input  logic [IDX_W-1:0]      cfg_addr,
    input  logic [WORD_W-1:0]     cfg_wdata
);

    // calibration registers
    logic [CAL_W-1:0]  cal_t1_reg, cal_t2_reg, cal_t3_reg, cal_p1_reg;
    logic [WORD_W-1:0] cal_p2_p5_reg, cal_p6_p9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_t1_reg    <= '0;
            cal_t2_reg    <= '0;
            cal_t3_reg    <= '0;
            cal_p1_reg    <= '0;
            cal_p2_p5_reg <= '0;
            cal_p6_p9_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_T1:    cal_t1_reg    <= cfg_wdata[CAL_W-1:0];
                CFG_T2:    cal_t2_reg    <= cfg_wdata[CAL_W-1:0];
                CFG_T3:    cal_t3_reg    <= cfg_wdata[CAL_W-1:0];
                CFG_P1:    cal_p1_reg    <= cfg_wdata[CAL_W-1:0];
                CFG_P2_P5: cal_p2_p5_reg <= cfg_wdata;
                CFG_P6_P9: cal_p6_p9_reg <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    logic signed [CAL_W-1:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t2 = cal_t2_reg;
    assign t3 = cal_t3_reg;
    assign p2 = cal_p2_p5_reg[15:0];
    assign p3 = cal_p2_p5_reg[31:16];
    assign p4 = cal_p2_p5_reg[47:32];
    assign p5 = cal_p2_p5_reg[63:48];
    assign p6 = cal_p6_p9_reg[15:0];
    assign p7 = cal_p6_p9_reg[31:16];
    assign p8 = cal_p6_p9_reg[47:32];
    assign p9 = cal_p6_p9_reg[63:48];

    // pipeline advance: stops only while the skid register is occupied
    logic sv_reg, ov_reg;
    logic en;
    assign en            = !sv_reg;
    assign s_axis_tready = en;

    logic [10:1] fv_reg;
    logic [5:1]  pv_reg;
    logic        dv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
            pv_reg <= '0;
        end
        else if (en)
        begin
            fv_reg <= {fv_reg[9:1], s_axis_tvalid};
            pv_reg <= {pv_reg[4:1], dv};
        end
    end

    // front stages: temperature then pressure divisor and dividend
    logic [RAW_W-1:0] at, ap;
    assign at = s_axis_tdata[RAW_W-1:0];
    assign ap = s_axis_tdata[2*RAW_W-1:RAW_W];

    logic signed [17:0] x_w;
    logic signed [16:0] d_w;
    assign x_w = $signed({1'b0, at[RAW_W-1:3]}) - $signed({1'b0, cal_t1_reg, 1'b0});
    assign d_w = $signed({1'b0, at[RAW_W-1:4]}) - $signed({1'b0, cal_t1_reg});

    logic [RAW_W-1:0]   ap_reg [1:8];
    logic signed [33:0] xt2_reg, dd_reg;
    logic [T_W-1:0]     tv1_reg;
    logic signed [35:0] ddt3_reg;
    logic [T_W-1:0]     tf_reg [3:10];
    logic [T_W-1:0]     tc_reg [4:10];
    logic signed [33:0] v1_reg;
    logic [63:0]        sq5_reg;
    logic signed [49:0] v1p5_reg, v1p2_reg, v1p5b_reg, v1p2b_reg;
    logic [63:0]        a6_reg, b6_reg, v2_7_reg, v1b_reg, m8_reg;
    logic [63:0]        v2_8_reg, den9_reg, nb9_reg, den10_reg, num10_reg;

    logic signed [T_W-1:0] tv1_w, tv2_w, tf_w, tf5_w;
    logic signed [T_W-1:0] dd_w;
    logic signed [19:0]    dd20;
    logic signed [67:0]    sq_w;
    logic signed [79:0]    a_w, b_w;
    logic [63:0]           v2_w, v1b_w, base_w, den_w, nb_w;
    logic [79:0]           m_w;
    logic [20:0]           pd_w;
    logic [75:0]           n_w;

    assign tv1_w  = $signed(xt2_reg[31:0]) >>> 11;
    assign dd_w   = $signed(dd_reg[31:0]) >>> 12;
    assign dd20   = dd_w[19:0];
    assign tv2_w  = $signed(ddt3_reg[31:0]) >>> 14;
    assign tf_w   = $signed(tv1_reg) + tv2_w;
    assign tf5_w  = ($signed(tf_reg[3]) <<< 2) + $signed(tf_reg[3]) + 32'sd128;
    assign sq_w   = v1_reg * v1_reg;
    assign a_w    = $signed(sq5_reg) * p6;
    assign b_w    = $signed(sq5_reg) * p3;
    assign v2_w   = a6_reg + ({{14{v1p5b_reg[49]}}, v1p5b_reg} << 17)
                  + ({{48{p4[15]}}, p4} << 35);
    assign v1b_w  = 64'($signed(b6_reg) >>> 8) + ({{14{v1p2b_reg[49]}}, v1p2b_reg} << 12);
    assign base_w = P_BIAS + v1b_reg;
    assign m_w    = base_w * cal_p1_reg;
    assign den_w  = 64'($signed(m8_reg) >>> 33);
    assign pd_w   = FULL_SCALE - {1'b0, ap_reg[8]};
    assign nb_w   = ({43'd0, pd_w} << 31) - v2_8_reg;
    assign n_w    = nb9_reg * P_SCALE;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            ap_reg[1] <= ap;
            xt2_reg   <= x_w * t2;
            dd_reg    <= d_w * d_w;
            // stage 2
            ap_reg[2] <= ap_reg[1];
            tv1_reg   <= tv1_w;
            ddt3_reg  <= dd20 * t3;
            // stage 3
            ap_reg[3] <= ap_reg[2];
            tf_reg[3] <= tf_w;
            // stage 4
            ap_reg[4] <= ap_reg[3];
            tf_reg[4] <= tf_reg[3];
            tc_reg[4] <= 32'(tf5_w >>> 8);
            v1_reg    <= $signed({{2{tf_reg[3][31]}}, tf_reg[3]}) - T_OFFSET;
            // stage 5
            ap_reg[5] <= ap_reg[4];
            tf_reg[5] <= tf_reg[4];
            tc_reg[5] <= tc_reg[4];
            sq5_reg   <= sq_w[63:0];
            v1p5_reg  <= v1_reg * p5;
            v1p2_reg  <= v1_reg * p2;
            // stage 6
            ap_reg[6] <= ap_reg[5];
            tf_reg[6] <= tf_reg[5];
            tc_reg[6] <= tc_reg[5];
            a6_reg    <= a_w[63:0];
            b6_reg    <= b_w[63:0];
            v1p5b_reg <= v1p5_reg;
            v1p2b_reg <= v1p2_reg;
            // stage 7
            ap_reg[7] <= ap_reg[6];
            tf_reg[7] <= tf_reg[6];
            tc_reg[7] <= tc_reg[6];
            v2_7_reg  <= v2_w;
            v1b_reg   <= v1b_w;
            // stage 8
            ap_reg[8] <= ap_reg[7];
            tf_reg[8] <= tf_reg[7];
            tc_reg[8] <= tc_reg[7];
            v2_8_reg  <= v2_7_reg;
            m8_reg    <= m_w[63:0];
            // stage 9
            tf_reg[9] <= tf_reg[8];
            tc_reg[9] <= tc_reg[8];
            den9_reg  <= den_w;
            nb9_reg   <= nb_w;
            // stage 10
            tf_reg[10] <= tf_reg[9];
            tc_reg[10] <= tc_reg[9];
            den10_reg  <= den9_reg;
            num10_reg  <= n_w[63:0];
        end
    end

    // divider
    side_t            side_in, side_out;
    logic [DIV_W-1:0] quo;

    assign side_in.tf  = tf_reg[10];
    assign side_in.tc  = tc_reg[10];
    assign side_in.inv = 1'b0;
    assign side_in.neg = 1'b0;

    bsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (fv_reg[10]),
        .num      (num10_reg),
        .den      (den10_reg),
        .side_in  (side_in),
        .out_vld  (dv),
        .quo      (quo),
        .side_out (side_out)
    );

    // post stages: quadratic correction of the quotient
    side_t       sd_reg [1:5];
    logic [63:0] p_reg [1:4];
    logic [63:0] ll_reg, p8p_reg, sq_reg, v2p_reg [3:4], pr_reg, sum_reg;
    logic [31:0] lh_reg;

    logic signed [63:0] ps_w;
    logic [31:0]        al_w, ah_w;
    logic [63:0]        lh_w;
    logic signed [79:0] p8p_w, pr_w;
    logic [63:0]        v1q_w, pf_w;

    assign ps_w  = $signed(p_reg[1]) >>> 13;
    assign al_w  = ps_w[31:0];
    assign ah_w  = ps_w[63:32];
    assign lh_w  = al_w * ah_w;
    assign p8p_w = $signed(p_reg[1]) * p8;
    assign pr_w  = $signed(sq_reg) * p9;
    assign v1q_w = 64'($signed(pr_reg) >>> 25);
    assign pf_w  = 64'($signed(sum_reg) >>> 8) + ({{48{p7[15]}}, p7} << 4);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg[1]  <= side_out;
            p_reg[1]   <= side_out.neg ? (~quo + 1'b1) : quo;
            sd_reg[2]  <= sd_reg[1];
            p_reg[2]   <= p_reg[1];
            ll_reg     <= al_w * al_w;
            lh_reg     <= lh_w[31:0];
            p8p_reg    <= p8p_w[63:0];
            sd_reg[3]  <= sd_reg[2];
            p_reg[3]   <= p_reg[2];
            sq_reg     <= ll_reg + {lh_reg[30:0], 33'd0};
            v2p_reg[3] <= 64'($signed(p8p_reg) >>> 19);
            sd_reg[4]  <= sd_reg[3];
            p_reg[4]   <= p_reg[3];
            v2p_reg[4] <= v2p_reg[3];
            pr_reg     <= pr_w[63:0];
            sd_reg[5]  <= sd_reg[4];
            sum_reg    <= p_reg[4] + v1q_w + v2p_reg[4];
        end
    end

    // output register with skid
    res_t res_w, out_reg, skid_reg;
    assign res_w.tf    = sd_reg[5].tf;
    assign res_w.tc    = sd_reg[5].tc;
    assign res_w.inv   = sd_reg[5].inv;
    assign res_w.press = sd_reg[5].inv ? '0 : pf_w[31:0];

    logic load_out, load_skid;
    assign load_out  = sv_reg ? m_axis_tready : (pv_reg[5] && (!ov_reg || m_axis_tready));
    assign load_skid = !sv_reg && pv_reg[5] && ov_reg && !m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else if (sv_reg)
        begin
            if (m_axis_tready)
            begin
                sv_reg <= 1'b0;
            end
        end
        else if (load_skid)
        begin
            sv_reg <= 1'b1;
        end
        else if (load_out)
        begin
            ov_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= sv_reg ? skid_reg : res_w;
        end
        if (load_skid)
        begin
            skid_reg <= res_w;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {out_reg.press, out_reg.tc, out_reg.tf};
    assign m_axis_tuser  = out_reg.inv;

    `ASSERT_CLK(a_skid_needs_out, clk, rst_n, sv_reg |-> ov_reg)
    `ASSERT_CLK(a_skid_fill_cause, clk, rst_n, $rose(sv_reg) |-> $past(ov_reg && !m_axis_tready))
    `ASSERT_NEVER(a_invalid_press_zero, clk, rst_n, ov_reg && out_reg.inv && (out_reg.press != '0))

endmodule

// ===== verif/tb_baro_sensor_compensation.sv =====
// self-checking testbench for the barometric sensor compensation pipeline
`timescale 1ns / 1ps
module tb_baro_sensor_compensation
    import bsc_pkg::*;
();

    localparam int LATENCY   = 81;
    localparam int WATCHDOG  = 20000;
    localparam int N_RANDOM  = 1000;

    typedef struct {
        logic signed [31:0] fine_temp;
        logic signed [31:0] temp_centi;
        logic [31:0]        press;
        logic               invalid;
    } comp_res_t;

    // one directed row: raw readings plus optional typed-in result
    typedef struct {
        logic [19:0] raw_t;
        logic [19:0] raw_p;
        bit          typed;
        comp_res_t   res;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [2*RAW_W-1:0] s_axis_tdata;   // raw_temp, raw_press
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [3*T_W-1:0] m_axis_tdata;     // fine_temp, temp_centi, press_q24_8
    logic m_axis_tuser;                 // press_invalid
    logic cfg_we;
    logic [IDX_W-1:0] cfg_addr;
    logic [WORD_W-1:0] cfg_wdata;

    // calibration copy held by the predictor
    logic [15:0] c_t1, c_t2, c_t3, c_p1;
    logic [63:0] c_p25, c_p69;

    comp_res_t pending_results[$];
    int errors;
    int idle_cycles;
    bit stall_free;

    baro_sensor_compensation u_dut (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic signed [63:0] pword(logic [63:0] packed_w, int k);
        return 64'(signed'(packed_w[16*k +: 16]));
    endfunction

    // compensation arithmetic with wrapping 32- and 64-bit passes
    function automatic comp_res_t compensate(logic [19:0] raw_t, logic [19:0] raw_p);
        comp_res_t r;
        logic signed [31:0] t1, t2, t3, x, d, tv1, tv2, tf, tc;
        logic signed [63:0] v1, v2, p, p1, dividend, q;
        logic [63:0] an, ad;
        t1 = {16'd0, c_t1};
        t2 = 32'(signed'(c_t2));
        t3 = 32'(signed'(c_t3));
        x = 32'(raw_t >> 3) - (t1 <<< 1);
        tv1 = (x * t2) >>> 11;
        d = 32'(raw_t >> 4) - t1;
        tv2 = (((d * d) >>> 12) * t3) >>> 14;
        tf = tv1 + tv2;
        tc = (tf * 32'sd5 + 32'sd128) >>> 8;
        r.fine_temp = tf;
        r.temp_centi = tc;
        r.press = '0;
        r.invalid = 1'b0;
        p1 = {48'd0, c_p1};
        v1 = 64'(tf) - 64'sd128000;
        v2 = v1 * v1 * pword(c_p69, 0);
        v2 = v2 + ((v1 * pword(c_p25, 3)) <<< 17);
        v2 = v2 + (pword(c_p25, 2) <<< 35);
        v1 = ((v1 * v1 * pword(c_p25, 1)) >>> 8) + ((v1 * pword(c_p25, 0)) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
        if (v1 == 0)
        begin
            r.invalid = 1'b1;
        end
        else
        begin
            p = 64'sd1048576 - 64'(raw_p);
            dividend = ((p <<< 31) - v2) * 64'sd3125;
            // unsigned magnitudes so the most negative value wraps cleanly
            an = dividend[63] ? 64'(-dividend) : dividend;
            ad = v1[63] ? 64'(-v1) : v1;
            q = signed'(an / ad);
            if (dividend[63] != v1[63])
                q = -q;
            p = q;
            v1 = (pword(c_p69, 3) * (p >>> 13) * (p >>> 13)) >>> 25;
            v2 = (pword(c_p69, 2) * p) >>> 19;
            p = ((p + v1 + v2) >>> 8) + (pword(c_p69, 1) <<< 4);
            r.press = p[31:0];
        end
        return r;
    endfunction

    task automatic write_cal(cfg_idx_t idx, logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_T1:    c_t1 = value[15:0];
            CFG_T2:    c_t2 = value[15:0];
            CFG_T3:    c_t3 = value[15:0];
            CFG_P1:    c_p1 = value[15:0];
            CFG_P2_P5: c_p25 = value;
            default:   c_p69 = value;
        endcase
    endtask

    // idle cycles on the input side, valid dropped only when there is a gap
    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (stall_free || $urandom_range(0, 2) != 0)
            n = 0;
        if (n != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // one input transfer, expectation recorded on acceptance
    task automatic send_item(logic [19:0] raw_t, logic [19:0] raw_p, bit typed,
                             comp_res_t res);
        comp_res_t e;
        random_gap();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {raw_p, raw_t};
        do @(posedge clk); while (!s_axis_tready);
        e = compensate(raw_t, raw_p);
        if (typed && e != res)
        begin
            $error("typed result disagrees with predictor for raw_temp %0d", raw_t);
            errors++;
        end
        pending_results.push_back(typed ? res : e);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic random_cal(bit extreme);
        write_cal(CFG_T1, extreme ? 64'hFFFF : 64'($urandom_range(20000, 40000)));
        write_cal(CFG_T2, extreme ? 64'h8000 : 64'($urandom_range(24000, 28000)));
        write_cal(CFG_T3, extreme ? 64'h7FFF : 64'($urandom & 32'hFFFF));
        write_cal(CFG_P1, extreme ? 64'hFFFF : 64'($urandom_range(30000, 40000)));
        write_cal(CFG_P2_P5, {$urandom, $urandom});
        write_cal(CFG_P6_P9, {$urandom, $urandom});
    endtask

    // output side: random backpressure and field compare
    always @(posedge clk)
    begin
        comp_res_t e;
        if (rst_n)
        begin
            m_axis_tready <= stall_free ? 1'b1 : ($urandom_range(0, 3) != 0);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    errors++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (m_axis_tdata[31:0] !== e.fine_temp)
                    begin
                        $error("fine_temp exp %0d got %0d", e.fine_temp,
                               $signed(m_axis_tdata[31:0]));
                        errors++;
                    end
                    if (m_axis_tdata[63:32] !== e.temp_centi)
                    begin
                        $error("temp_centi exp %0d got %0d", e.temp_centi,
                               $signed(m_axis_tdata[63:32]));
                        errors++;
                    end
                    if (m_axis_tdata[95:64] !== e.press)
                    begin
                        $error("press_q24_8 exp %h got %h", e.press, m_axis_tdata[95:64]);
                        errors++;
                    end
                    if (m_axis_tuser !== e.invalid)
                    begin
                        $error("press_invalid exp %b got %b", e.invalid, m_axis_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("tb_baro_sensor_compensation NOT OK");
            $finish;
        end
    end

    initial
    begin
        dir_row_t rows[$];
        comp_res_t z;
        logic [19:0] rt, rp;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_T1;
        cfg_wdata = '0;
        c_t1 = '0; c_t2 = '0; c_t3 = '0; c_p1 = '0; c_p25 = '0; c_p69 = '0;
        errors = 0;
        idle_cycles = 0;
        stall_free = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset every calibration word is zero: result is all zero and invalid
        z.fine_temp = 0; z.temp_centi = 0; z.press = 0; z.invalid = 1'b1;
        rows.push_back('{20'd0, 20'd0, 1'b1, z});
        rows.push_back('{20'hFFFFF, 20'hFFFFF, 1'b1, z});
        rows.push_back('{20'hFFFFF, 20'd0, 1'b1, z});
        rows.push_back('{20'd0, 20'hFFFFF, 1'b1, z});
        foreach (rows[i])
            send_item(rows[i].raw_t, rows[i].raw_p, rows[i].typed, rows[i].res);
        drain();

        // typical calibration, extreme and mid-range raw readings
        write_cal(CFG_T1, 64'd27504);
        write_cal(CFG_T2, 64'd26435);
        write_cal(CFG_T3, 64'hFC18);
        write_cal(CFG_P1, 64'd36477);
        write_cal(CFG_P2_P5, {16'd140, 16'd2855, 16'd3024, 16'hD6D0});
        write_cal(CFG_P6_P9, {16'd6000, 16'hFFF4, 16'hD8BA, 16'hFFF9});
        rows.delete();
        rows.push_back('{20'd0, 20'd0, 1'b0, z});
        rows.push_back('{20'hFFFFF, 20'hFFFFF, 1'b0, z});
        rows.push_back('{20'd519888, 20'd415148, 1'b0, z});
        rows.push_back('{20'h55555, 20'hAAAAA, 1'b0, z});
        rows.push_back('{20'hAAAAA, 20'h55555, 1'b0, z});
        rows.push_back('{20'd1048575, 20'd0, 1'b0, z});
        foreach (rows[i])
            send_item(rows[i].raw_t, rows[i].raw_p, rows[i].typed, rows[i].res);
        drain();

        // extreme calibration: overflow of both passes
        random_cal(1'b1);
        write_cal(CFG_P2_P5, 64'h8000_7FFF_8000_7FFF);
        write_cal(CFG_P6_P9, 64'h7FFF_8000_7FFF_8000);
        send_item(20'd0, 20'hFFFFF, 1'b0, z);
        send_item(20'hFFFFF, 20'd0, 1'b0, z);
        send_item(20'h80000, 20'h7FFFF, 1'b0, z);
        drain();

        // random phases under several calibration settings
        for (int ph = 0; ph < 5; ph++)
        begin
            random_cal(ph == 4);
            stall_free = (ph == 2);
            for (int i = 0; i < N_RANDOM / 5; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    rt = 20'($urandom);
                else
                    rt = 20'($urandom_range(400000, 600000));
                rp = 20'($urandom);
                send_item(rt, rp, 1'b0, z);
                if (i == 100)
                begin
                    // hold off until the pipeline has emptied
                    s_axis_tvalid <= 1'b0;
                    while (pending_results.size() != 0)
                        @(posedge clk);
                end
            end
            stall_free = 1'b0;
            drain();
        end

        if (errors == 0)
            $display("tb_baro_sensor_compensation OK");
        else
            $display("tb_baro_sensor_compensation NOT OK");
        $finish;
    end
endmodule
